FILE: hdl/ppf_pkg.sv
package ppf_pkg;

    // Field widths
    localparam int SW     = 16;            // sample width
    localparam int FB     = 8;             // fraction bits of the results
    localparam int IDXW   = 11;            // widest index the window registers can name
    localparam int WSW    = 10;            // window_start width
    localparam int WEW    = 11;            // window_end width
    localparam int AMPW   = 26;            // amplitude width
    localparam int POSW   = 18;            // position width

    // Derived arithmetic widths
    localparam int SQW    = 2 * SW;        // |r-l| squared
    localparam int B2W    = SW + 2;        // 2p-l-r when both neighbors are lower
    localparam int NUMW   = SQW + FB;      // divider dividend width
    localparam int DENW   = B2W + 3;       // divider divisor width (8*B2)

    // Job queue between front and back
    localparam int QDEPTH = 2;

    // Default sample limit per waveform
    localparam int MAX_SAMPLES_DEF = 1024;

    // Configuration register indexes
    localparam logic REG_WSTART = 1'b0;
    localparam logic REG_WEND   = 1'b1;

    // Reset values of the configuration registers
    localparam logic [WSW-1:0] WSTART_RST = '0;
    localparam logic [WEW-1:0] WEND_RST   = WEW'(1024);

    // One finished waveform, handed from front to back
    typedef struct packed {
        logic                 ok;
        logic signed [SW-1:0] p;
        logic signed [SW-1:0] l;
        logic signed [SW-1:0] r;
        logic [IDXW-1:0]      idx;
    } t_job;

endpackage

FILE: hdl/ppf_sample_if.sv
interface ppf_sample_if;
    logic                          valid;
    logic                          ready;
    logic signed [ppf_pkg::SW-1:0] sample;
    logic                          last_sample;

    modport source(output valid, sample, last_sample, input ready);
    modport sink(input valid, sample, last_sample, output ready);
endinterface

FILE: hdl/ppf_result_if.sv
interface ppf_result_if;
    logic                            valid;
    logic                            ready;
    logic                            valid_res;
    logic                            hit;
    logic signed [ppf_pkg::AMPW-1:0] amplitude;
    logic [ppf_pkg::POSW-1:0]        position;

    modport source(output valid, valid_res, hit, amplitude, position, input ready);
    modport sink(input valid, valid_res, hit, amplitude, position, output ready);
endinterface

FILE: hdl/ppf_front.sv
module ppf_front #(
    parameter int MAX_SAMPLES = ppf_pkg::MAX_SAMPLES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    ppf_sample_if.sink                i_smp,
    input  logic [ppf_pkg::WSW-1:0]   i_wstart,
    input  logic [ppf_pkg::WEW-1:0]   i_wend,
    input  logic                      i_full,
    output logic                      o_push,
    output ppf_pkg::t_job             o_job
);

    localparam int IW = $clog2(MAX_SAMPLES + 1);
    localparam int CW = (IW > ppf_pkg::IDXW) ? IW : ppf_pkg::IDXW;

    logic [IW-1:0]                  r_idx, n_idx;
    logic signed [ppf_pkg::SW-1:0]  r_best, n_best;
    logic signed [ppf_pkg::SW-1:0]  r_left, n_left;
    logic signed [ppf_pkg::SW-1:0]  r_right, n_right;
    logic signed [ppf_pkg::SW-1:0]  r_prev, n_prev;
    logic [ppf_pkg::IDXW-1:0]       r_bidx, n_bidx;
    logic                           r_rpend, n_rpend;
    logic                           r_found, n_found;

    logic                           acc;
    logic                           active;
    logic                           inwin;
    logic [CW-1:0]                  idx_ext;

    // Stall only when the job queue cannot take a finished waveform
    assign i_smp.ready = !i_full;
    assign acc         = i_smp.valid && i_smp.ready;

    always_comb begin
        n_idx   = r_idx;
        n_best  = r_best;
        n_left  = r_left;
        n_right = r_right;
        n_prev  = r_prev;
        n_bidx  = r_bidx;
        n_rpend = r_rpend;
        n_found = r_found;

        idx_ext = CW'(r_idx);
        active  = r_idx < IW'(MAX_SAMPLES);
        inwin   = (idx_ext >= CW'(i_wstart)) && (idx_ext < CW'(i_wend));

        // Track first maximum in window and its neighbors
        if (acc && active) begin
            if (r_rpend) begin
                n_right = i_smp.sample;
                n_rpend = 1'b0;
            end
            if (inwin && (!r_found || i_smp.sample > r_best)) begin
                n_best  = i_smp.sample;
                n_bidx  = idx_ext[ppf_pkg::IDXW-1:0];
                n_left  = r_prev;
                n_rpend = 1'b1;
                n_found = 1'b1;
            end
            n_prev = i_smp.sample;
            n_idx  = r_idx + IW'(1);
        end

        // Hand the waveform summary to the back end
        o_push    = acc && i_smp.last_sample;
        o_job.ok  = n_found && (n_bidx != '0) && !n_rpend;
        o_job.p   = n_best;
        o_job.l   = n_left;
        o_job.r   = n_right;
        o_job.idx = n_bidx;

        // Start a new waveform after the last sample
        if (o_push) begin
            n_idx   = '0;
            n_best  = '0;
            n_left  = '0;
            n_right = '0;
            n_prev  = '0;
            n_bidx  = '0;
            n_rpend = 1'b0;
            n_found = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_best  <= '0;
            r_left  <= '0;
            r_right <= '0;
            r_prev  <= '0;
            r_bidx  <= '0;
            r_rpend <= 1'b0;
            r_found <= 1'b0;
        end else begin
            r_idx   <= n_idx;
            r_best  <= n_best;
            r_left  <= n_left;
            r_right <= n_right;
            r_prev  <= n_prev;
            r_bidx  <= n_bidx;
            r_rpend <= n_rpend;
            r_found <= n_found;
        end
    end

endmodule

FILE: hdl/ppf_fifo.sv
module ppf_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ppf_pkg::t_job  i_job,
    output logic           o_full,
    input  logic           i_pop,
    output ppf_pkg::t_job  o_job,
    output logic           o_empty
);

    localparam int PW = (ppf_pkg::QDEPTH > 1) ? $clog2(ppf_pkg::QDEPTH) : 1;
    localparam int CNTW = $clog2(ppf_pkg::QDEPTH + 1);

    ppf_pkg::t_job     r_mem [ppf_pkg::QDEPTH];
    logic [PW-1:0]     r_wp, r_rp;
    logic [CNTW-1:0]   r_cnt;
    logic              do_push, do_pop;

    assign o_full  = r_cnt == CNTW'(ppf_pkg::QDEPTH);
    assign o_empty = r_cnt == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rp];

    // Store entries
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == PW'(ppf_pkg::QDEPTH - 1)) ? '0 : r_wp + PW'(1);
            end
            if (do_pop) begin
                r_rp <= (r_rp == PW'(ppf_pkg::QDEPTH - 1)) ? '0 : r_rp + PW'(1);
            end
            r_cnt <= r_cnt + CNTW'(do_push) - CNTW'(do_pop);
        end
    end

endmodule

FILE: hdl/ppf_div.sv
module ppf_div #(
    parameter int NW = ppf_pkg::NUMW,
    parameter int DW = ppf_pkg::DENW
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quo
);

    localparam int CNTW = $clog2(NW + 1);

    logic [NW-1:0]   r_num;
    logic [NW-1:0]   r_quo;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_den;
    logic [CNTW-1:0] r_cnt;
    logic            r_busy;
    logic            r_done;

    logic [DW:0]     rem2;
    logic            ge;
    logic            rnd;

    // One quotient bit per cycle, restoring
    assign rem2 = {r_rem, r_num[NW-1]};
    assign ge   = rem2 >= {1'b0, r_den};

    // Round half away from zero on the final remainder
    assign rnd    = {r_rem, 1'b0} >= {1'b0, r_den};
    assign o_quo  = r_quo + NW'(rnd);
    assign o_done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNTW'(NW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNTW'(1);
                if (r_cnt == CNTW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
            r_quo <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NW-2:0], 1'b0};
            r_quo <= {r_quo[NW-2:0], ge};
            r_rem <= ge ? DW'(rem2 - {1'b0, r_den}) : rem2[DW-1:0];
        end
    end

endmodule

FILE: hdl/ppf_back.sv
module ppf_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  ppf_pkg::t_job  i_job,
    output logic           o_pop,
    ppf_result_if.source   o_res
);

    localparam int AEW = ppf_pkg::NUMW + 2;
    localparam int PEW = ppf_pkg::NUMW + 1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_AMP  = 3'd2;
    localparam logic [2:0] S_POS  = 3'd3;
    localparam logic [2:0] S_FIN  = 3'd4;

    localparam logic signed [AEW-1:0] AMP_MAX =
        $signed({{(AEW - ppf_pkg::AMPW + 1){1'b0}}, {(ppf_pkg::AMPW - 1){1'b1}}});
    localparam logic signed [AEW-1:0] AMP_MIN = ~AMP_MAX;
    localparam logic [PEW-1:0] POS_MAX =
        {{(PEW - ppf_pkg::POSW){1'b0}}, {ppf_pkg::POSW{1'b1}}};

    logic [2:0]                      r_st, n_st;
    ppf_pkg::t_job                   r_job;
    logic [ppf_pkg::SW-1:0]          r_x;
    logic [ppf_pkg::B2W-1:0]         r_b2;
    logic                            r_neg;
    logic [ppf_pkg::NUMW-1:0]        r_ac;
    logic [ppf_pkg::NUMW-1:0]        r_pc;

    logic                            r_ov;
    logic                            r_vr;
    logic                            r_hit;
    logic signed [ppf_pkg::AMPW-1:0] r_amp;
    logic [ppf_pkg::POSW-1:0]        r_pos;

    logic signed [ppf_pkg::SW:0]     diff;
    logic [ppf_pkg::SW-1:0]          x;
    logic signed [ppf_pkg::SW+2:0]   b2s;
    logic [ppf_pkg::B2W-1:0]         b2;
    logic                            interp;
    logic [ppf_pkg::SQW-1:0]         sq;

    logic                            div_start;
    logic [ppf_pkg::NUMW-1:0]        div_num;
    logic [ppf_pkg::DENW-1:0]        div_den;
    logic                            div_done;
    logic [ppf_pkg::NUMW-1:0]        div_quo;

    logic signed [AEW-1:0]           amp_sum;
    logic signed [AEW-1:0]           amp_sat;
    logic [PEW-1:0]                  base;
    logic [PEW-1:0]                  pos_sum;
    logic [PEW-1:0]                  pos_sat;
    logic                            load_out;

    ppf_div #(
        .NW (ppf_pkg::NUMW),
        .DW (ppf_pkg::DENW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // Set up the correction terms
    always_comb begin
        diff   = (ppf_pkg::SW + 1)'(r_job.r) - (ppf_pkg::SW + 1)'(r_job.l);
        x      = diff[ppf_pkg::SW] ? ppf_pkg::SW'(-diff) : diff[ppf_pkg::SW-1:0];
        b2s    = ((ppf_pkg::SW + 3)'(r_job.p) <<< 1) - (ppf_pkg::SW + 3)'(r_job.l)
                 - (ppf_pkg::SW + 3)'(r_job.r);
        b2     = b2s[ppf_pkg::B2W-1:0];
        interp = r_job.ok && (r_job.l < r_job.p) && (r_job.r < r_job.p);
        sq     = ppf_pkg::SQW'(x) * ppf_pkg::SQW'(x);
    end

    // Sequence the two divisions and the result load
    always_comb begin
        n_st      = r_st;
        o_pop     = 1'b0;
        div_start = 1'b0;
        div_num   = ppf_pkg::NUMW'(sq) << ppf_pkg::FB;
        div_den   = ppf_pkg::DENW'(b2) << 3;
        load_out  = 1'b0;
        unique case (r_st)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_st  = S_PREP;
                end
            end
            S_PREP: begin
                div_start = interp;
                n_st      = interp ? S_AMP : S_FIN;
            end
            S_AMP: begin
                div_num = ppf_pkg::NUMW'(r_x) << ppf_pkg::FB;
                div_den = ppf_pkg::DENW'(r_b2) << 1;
                if (div_done) begin
                    div_start = 1'b1;
                    n_st      = S_POS;
                end
            end
            S_POS: begin
                if (div_done) begin
                    n_st = S_FIN;
                end
            end
            S_FIN: begin
                if (!r_ov || o_res.ready) begin
                    load_out = 1'b1;
                    n_st     = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase
    end

    // Combine raw peak with corrections and saturate
    always_comb begin
        amp_sum = (AEW'(r_job.p) <<< ppf_pkg::FB) + AEW'($signed({1'b0, r_ac}));
        if (amp_sum > AMP_MAX) begin
            amp_sat = AMP_MAX;
        end else if (amp_sum < AMP_MIN) begin
            amp_sat = AMP_MIN;
        end else begin
            amp_sat = amp_sum;
        end
        base = PEW'(r_job.idx) << ppf_pkg::FB;
        if (r_neg) begin
            pos_sum = (PEW'(r_pc) > base) ? '0 : base - PEW'(r_pc);
        end else begin
            pos_sum = base + PEW'(r_pc);
        end
        pos_sat = (pos_sum > POS_MAX) ? POS_MAX : pos_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (load_out) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    // Hold job data and intermediate terms
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_job;
        end
        if (r_st == S_PREP) begin
            r_x   <= x;
            r_b2  <= b2;
            r_neg <= interp && diff[ppf_pkg::SW];
            r_ac  <= '0;
            r_pc  <= '0;
        end
        if (r_st == S_AMP && div_done) begin
            r_ac <= div_quo;
        end
        if (r_st == S_POS && div_done) begin
            r_pc <= div_quo;
        end
        if (load_out) begin
            r_vr  <= r_job.ok;
            r_hit <= r_job.ok && (amp_sat > AEW'(0));
            r_amp <= r_job.ok ? amp_sat[ppf_pkg::AMPW-1:0] : '0;
            r_pos <= r_job.ok ? pos_sat[ppf_pkg::POSW-1:0] : '0;
        end
    end

    assign o_res.valid     = r_ov;
    assign o_res.valid_res = r_vr;
    assign o_res.hit       = r_hit;
    assign o_res.amplitude = r_amp;
    assign o_res.position  = r_pos;

endmodule

FILE: hdl/parabolic_peak_finder_core.sv
// Samples are taken one per cycle while the job queue has room.
// When the peak is interpolated, the result waits on two divisions, run one after the other
// on the shared bit-serial divider; otherwise no division is run.
// The back end takes one waveform at a time; a two-entry queue lets the next ones stream in.
// Reset (synchronous, active low) clears the front-end waveform state, empties the queue and
// clears the output valid; the window registers return to start 0 and end 1024.
module parabolic_peak_finder_core #(
    parameter int MAX_SAMPLES = ppf_pkg::MAX_SAMPLES_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    ppf_sample_if.sink               i_smp,
    ppf_result_if.source             o_res,
    input  logic                     i_cfg_we,
    input  logic                     i_cfg_idx,
    input  logic [ppf_pkg::WEW-1:0]  i_cfg_wdata
);

    logic [ppf_pkg::WSW-1:0] r_wstart;
    logic [ppf_pkg::WEW-1:0] r_wend;

    logic                    push;
    logic                    pop;
    logic                    full;
    logic                    empty;
    ppf_pkg::t_job           job_in;
    ppf_pkg::t_job           job_out;

    // Write window registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wstart <= ppf_pkg::WSTART_RST;
            r_wend   <= ppf_pkg::WEND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ppf_pkg::REG_WSTART: r_wstart <= i_cfg_wdata[ppf_pkg::WSW-1:0];
                ppf_pkg::REG_WEND:   r_wend   <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    ppf_front #(
        .MAX_SAMPLES (MAX_SAMPLES)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_smp    (i_smp),
        .i_wstart (r_wstart),
        .i_wend   (r_wend),
        .i_full   (full),
        .o_push   (push),
        .o_job    (job_in)
    );

    ppf_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (empty)
    );

    ppf_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_res   (o_res)
    );

endmodule
